>>> hdl/pva_pkg.sv
// Shared types, constants and codes of the power vote aggregator.
package pva_pkg;

   localparam int NumTypesDefault = 32;
   localparam logic [15:0] SleepCeil = 16'hFFFF;
   localparam logic [15:0] SleepReset = 16'd1000;
   localparam logic [5:0] DtimReset = 6'd10;
   localparam logic [48:0] DeadlineInf = {49{1'b1}};
   localparam logic [31:0] WakeMax = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ACT_PROGRAM    = 3'd0,
      ACT_REGISTER   = 3'd1,
      ACT_UNREGISTER = 3'd2,
      ACT_QUERY      = 3'd3,
      ACT_TICK       = 3'd4,
      ACT_ENFORCE    = 3'd5,
      ACT_RESTORE    = 3'd6,
      ACT_NONE       = 3'd7
   } action_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [4:0]  type_index;
      logic [47:0] now_ms;
      logic [15:0] sleep_ms;
      logic [5:0]  dtim_value;
      logic [31:0] hold_ms;
      logic        never_expires;
      logic [7:0]  max_count;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        registered;
      logic        applied;
      logic [15:0] cpu_sleep_ms;
      logic [5:0]  wifi_dtim;
      logic [31:0] next_wake_ms;
   } rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch the item
      logic update;    // apply the per-entry action
      logic scan_clr;  // reset minima accumulators
      logic scan_en;   // fold one entry into the minima
      logic finish;    // commit chosen and driven values
      logic emit;      // present the result
   } pva_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic do_eval;
   } pva_sts_type;

endpackage

>>> hdl/pva_datapath.sv
// Datapath: policy table, vote counts, deadlines and the sequential scan.
module pva_datapath
   import pva_pkg::*;
#(
   parameter int NumTypes = NumTypesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_in,
   input  logic [5:0]  default_dtim,
   input  pva_cmd_type cmd,
   output pva_sts_type sts,
   output rsp_type     rsp_out
);
   localparam int IdxW = (NumTypes > 1) ? $clog2(NumTypes) : 1;

   logic [15:0] pol_sleep_ff [NumTypes];
   logic [5:0]  pol_dtim_ff  [NumTypes];
   logic [31:0] pol_hold_ff  [NumTypes];
   logic        pol_never_ff [NumTypes];
   logic [7:0]  pol_max_ff   [NumTypes];
   logic [7:0]  count_ff     [NumTypes];
   logic [48:0] dl_ff        [NumTypes];

   req_type     item_ff;
   logic        valid_ff;
   logic [IdxW-1:0] scan_ff;
   logic [15:0] min_s_ff;
   logic [5:0]  min_d_ff;
   logic [48:0] min_dl_ff;
   logic [15:0] chosen_s_ff, drive_s_ff;
   logic [5:0]  chosen_d_ff, drive_d_ff;
   logic        forced_ff, reg_ff, eval_ff;
   logic [15:0] old_s_ff;
   logic [5:0]  old_d_ff;
   rsp_type     rsp_ff;

   logic [IdxW-1:0] tix;
   logic [48:0] now49, cur_dl;
   logic        expired;
   logic [8:0]  inc;
   logic [7:0]  new_cnt;
   logic [48:0] diff;

   assign tix    = IdxW'(item_ff.type_index);
   assign now49  = {1'b0, item_ff.now_ms};
   assign cur_dl = dl_ff[tix];
   assign expired = cur_dl <= now49;

   always_comb begin
      inc = {1'b0, (expired ? 8'd0 : count_ff[tix])} + 9'd1;
      new_cnt = (inc > {1'b0, pol_max_ff[tix]}) ? pol_max_ff[tix] : inc[7:0];
   end

   assign sts.scan_last = (scan_ff == IdxW'(NumTypes - 1));
   assign sts.do_eval   = eval_ff;
   assign diff = min_dl_ff - now49;
   assign rsp_out = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumTypes; i++) begin
            pol_sleep_ff[i] <= '0;
            pol_dtim_ff[i]  <= '0;
            pol_hold_ff[i]  <= '0;
            pol_never_ff[i] <= 1'b0;
            pol_max_ff[i]   <= '0;
            count_ff[i]     <= '0;
            dl_ff[i]        <= '0;
         end
         chosen_s_ff <= SleepReset;
         drive_s_ff  <= SleepReset;
         chosen_d_ff <= DtimReset;
         drive_d_ff  <= DtimReset;
         forced_ff   <= 1'b0;
         eval_ff     <= 1'b0;
         scan_ff     <= '0;
      end else begin
         if (cmd.capture) begin
            item_ff  <= req_in;
            valid_ff <= (int'(req_in.type_index) < NumTypes);
            old_s_ff <= drive_s_ff;
            old_d_ff <= drive_d_ff;
            reg_ff   <= 1'b0;
            eval_ff  <= 1'b0;
         end
         if (cmd.update) begin
            unique case (action_type'(item_ff.action))
               ACT_PROGRAM: if (valid_ff) begin
                  pol_sleep_ff[tix] <= item_ff.sleep_ms;
                  pol_dtim_ff[tix]  <= item_ff.dtim_value;
                  pol_hold_ff[tix]  <= item_ff.hold_ms;
                  pol_never_ff[tix] <= item_ff.never_expires;
                  pol_max_ff[tix]   <= item_ff.max_count;
               end
               ACT_REGISTER: if (valid_ff) begin
                  count_ff[tix] <= new_cnt;
                  dl_ff[tix] <= pol_never_ff[tix] ? DeadlineInf
                              : now49 + {17'd0, pol_hold_ff[tix]};
                  eval_ff <= 1'b1;
               end
               ACT_UNREGISTER: if (valid_ff && count_ff[tix] != 8'd0) begin
                  count_ff[tix] <= count_ff[tix] - 8'd1;
                  if (count_ff[tix] == 8'd1) begin
                     dl_ff[tix] <= '0;
                     eval_ff <= 1'b1;
                  end
               end
               ACT_QUERY: if (valid_ff) begin
                  if (expired) count_ff[tix] <= '0;
                  reg_ff <= !expired && count_ff[tix] != 8'd0;
               end
               ACT_TICK: eval_ff <= 1'b1;
               ACT_ENFORCE: begin
                  drive_s_ff <= item_ff.sleep_ms;
                  drive_d_ff <= item_ff.dtim_value;
                  forced_ff  <= 1'b1;
               end
               ACT_RESTORE: begin
                  drive_s_ff <= chosen_s_ff;
                  drive_d_ff <= chosen_d_ff;
                  forced_ff  <= 1'b0;
               end
               default: ;
            endcase
         end
         if (cmd.scan_clr) begin
            scan_ff   <= '0;
            min_s_ff  <= SleepCeil;
            min_d_ff  <= default_dtim;
            min_dl_ff <= DeadlineInf;
         end else if (cmd.scan_en) begin
            if (dl_ff[scan_ff] > now49) begin
               if (pol_sleep_ff[scan_ff] < min_s_ff) min_s_ff <= pol_sleep_ff[scan_ff];
               if (pol_dtim_ff[scan_ff] < min_d_ff) min_d_ff <= pol_dtim_ff[scan_ff];
               if (dl_ff[scan_ff] < min_dl_ff) min_dl_ff <= dl_ff[scan_ff];
            end
            scan_ff <= scan_ff + IdxW'(1);
         end
         if (cmd.finish) begin
            chosen_s_ff <= min_s_ff;
            chosen_d_ff <= min_d_ff;
            if (!forced_ff) begin
               drive_s_ff <= min_s_ff;
               drive_d_ff <= min_d_ff;
            end
         end
         if (cmd.emit) begin
            rsp_ff.status <= !valid_ff && item_ff.action <= 3'(ACT_QUERY);
            rsp_ff.registered <= reg_ff;
            rsp_ff.applied <= (drive_s_ff != old_s_ff) || (drive_d_ff != old_d_ff);
            rsp_ff.cpu_sleep_ms <= drive_s_ff;
            rsp_ff.wifi_dtim <= drive_d_ff;
            if (min_dl_ff == DeadlineInf) rsp_ff.next_wake_ms <= '0;
            else if (diff[48:32] != 17'd0) rsp_ff.next_wake_ms <= WakeMax;
            else rsp_ff.next_wake_ms <= diff[31:0];
         end
      end
   end
endmodule

>>> hdl/pva_ctrl.sv
// Controller: sequences capture, update, entry scan, commit and result.
module pva_ctrl
   import pva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        done,
   input  pva_sts_type sts,
   output pva_cmd_type cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_UPDATE, ST_CLEAR, ST_SCAN, ST_FINISH, ST_EMIT
   } state_type;

   state_type state_ff;
   logic      done_ff;

   assign busy = state_ff != ST_IDLE;
   assign done = done_ff;

   always_comb begin
      cmd = '0;
      cmd.capture  = state_ff == ST_IDLE && start;
      cmd.update   = state_ff == ST_UPDATE;
      cmd.scan_clr = state_ff == ST_CLEAR;
      cmd.scan_en  = state_ff == ST_SCAN;
      // Only actions that evaluate commit the scanned minima.
      cmd.finish   = state_ff == ST_FINISH && sts.do_eval;
      cmd.emit     = state_ff == ST_EMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE:   if (start) state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= ST_CLEAR;
            ST_CLEAR:  state_ff <= ST_SCAN;
            ST_SCAN:   if (sts.scan_last) state_ff <= ST_FINISH;
            ST_FINISH: state_ff <= ST_EMIT;
            ST_EMIT: begin
               state_ff <= ST_IDLE;
               done_ff  <= 1'b1;
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

>>> hdl/power_vote_aggregator_core.sv
// Top level of the power vote aggregator.
// Each item passes from the accepting edge through update, clear, the entry scan, finish
// and emit to rsp_valid; the entry scan visits one policy entry per cycle for minima and
// the next deadline. busy is high from acceptance and drops as rsp_valid rises, so a new
// item is accepted only after the previous one is through. The result shows for one cycle
// with rsp_valid and cannot be held off. csr_ready is always high; write only while idle.
module power_vote_aggregator_core
   import pva_pkg::*;
#(
   parameter int NumTypes = NumTypesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [5:0] csr_data
);
   logic [5:0]  dtim_ff;
   pva_cmd_type cmd;
   pva_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) dtim_ff <= DtimReset;
      else if (csr_valid) dtim_ff <= csr_data;
   end

   pva_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .done(rsp_valid), .sts(sts), .cmd(cmd)
   );

   pva_datapath #(.NumTypes(NumTypes)) u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .default_dtim(dtim_ff),
      .cmd(cmd), .sts(sts), .rsp_out(rsp_data)
   );
endmodule
